// ===== design/mod97_check_digit_stream_assert.svh =====
// Assertion macros shared by the checker of the mod 97 check digit stream.
// Depends on nothing; files that assert include it by its bare name.
`ifndef MOD97_CHECK_DIGIT_STREAM_ASSERT_SVH
`define MOD97_CHECK_DIGIT_STREAM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== design/mcd_pkg.sv =====
// Package of the mod 97 check digit stream: types, character codes and
// constant residue tables. Depends on nothing.
package mcd_pkg;

   localparam int unsigned ResDepth    = 97;
   localparam int unsigned DigitScale  = 10;
   localparam int unsigned LetterScale = 100;
   localparam int unsigned CheckBase   = 98;

   localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] LETTER_BASE  = 8'(DigitScale);
   localparam logic [7:0] MODULUS      = 8'(ResDepth);
   localparam logic [6:0] RESIDUE_ONE  = 7'd1;

   typedef logic [6:0] residue_type;
   typedef residue_type residue_table_type [ResDepth];
   typedef logic [7:0] digits_table_type [ResDepth];

   typedef enum logic [1:0] {
      KIND_SKIP,
      KIND_DIGIT,
      KIND_LETTER,
      KIND_BAD
   } char_kind_type;

   typedef struct packed {
      char_kind_type kind;
      logic [5:0]    value;
   } char_class_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
      logic       operation;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } stage_type;

   typedef struct packed {
      logic [3:0] check_tens;
      logic [3:0] check_ones;
      logic       verified;
      logic       invalid_input;
   } result_type;

   function automatic residue_table_type build_mul_table(int unsigned factor);
      residue_table_type t;
      int unsigned       acc;
      acc = 0;
      for (int i = 0; i < ResDepth; i++) begin
         t[i] = residue_type'(acc);
         acc = acc + factor;
         if (acc >= ResDepth) begin
            acc = acc - ResDepth;
         end
      end
      return t;
   endfunction

   function automatic digits_table_type build_check_table();
      digits_table_type  t;
      residue_table_type m;
      int unsigned       chk;
      int unsigned       tens;
      m = build_mul_table(LetterScale % ResDepth);
      for (int i = 0; i < ResDepth; i++) begin
         chk = CheckBase - int'(m[i]);
         tens = 0;
         for (int k = 0; k < 10; k++) begin
            if (chk >= DigitScale) begin
               chk = chk - DigitScale;
               tens = tens + 1;
            end
         end
         t[i] = {4'(tens), 4'(chk)};
      end
      return t;
   endfunction

   localparam residue_table_type MUL_DIGIT_TABLE  = build_mul_table(DigitScale);
   localparam residue_table_type MUL_LETTER_TABLE =
      build_mul_table(LetterScale % ResDepth);
   localparam digits_table_type  CHECK_TABLE      = build_check_table();

   function automatic char_class_type classify(logic [7:0] c);
      char_class_type r;
      r.kind  = KIND_BAD;
      r.value = '0;
      if (c == CHAR_HYPHEN) begin
         r.kind = KIND_SKIP;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r.kind  = KIND_DIGIT;
         r.value = 6'(c - CHAR_ZERO);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r.kind  = KIND_LETTER;
         r.value = 6'(c - CHAR_UPPER_A + LETTER_BASE);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r.kind  = KIND_LETTER;
         r.value = 6'(c - CHAR_LOWER_A + LETTER_BASE);
      end
      return r;
   endfunction

endpackage

// ===== design/mcd_in_reg.sv =====
// Input register of the mod 97 check digit stream: holds one request beat.
// Depends on mcd_pkg.
module mcd_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mcd_pkg::item_type req_item,
   input  logic              advance,
   output mcd_pkg::stage_type stage
);
   import mcd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

// ===== design/mcd_fold.sv =====
// Residue fold and result register of the mod 97 check digit stream.
// Depends on mcd_pkg for the character classes and the residue tables.
module mcd_fold (
   input  logic                clock,
   input  logic                reset,
   input  mcd_pkg::stage_type  stage,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mcd_pkg::result_type result
);
   import mcd_pkg::*;

   residue_type    residue_ff, residue_in;
   logic           bad_ff, bad_in;
   logic           valid_ff, valid_in;
   result_type     result_ff, result_in;
   char_class_type cls;
   residue_type    base;
   logic [7:0]     sum;
   residue_type    folded;
   residue_type    res_now;
   logic           bad_now;
   logic           fold_en;
   logic [7:0]     digits;
   logic           finish;

   always_comb begin
      cls     = classify(stage.item.char_code);
      base    = (cls.kind == KIND_LETTER) ? MUL_LETTER_TABLE[residue_ff]
                                          : MUL_DIGIT_TABLE[residue_ff];
      sum     = {1'b0, base} + {2'b00, cls.value};
      folded  = (sum >= MODULUS) ? 7'(sum - MODULUS) : sum[6:0];
      fold_en = ((cls.kind == KIND_DIGIT) || (cls.kind == KIND_LETTER)) && !bad_ff;
      bad_now = bad_ff || (cls.kind == KIND_BAD);
      res_now = fold_en ? folded : residue_ff;
      digits  = CHECK_TABLE[res_now];
   end

   assign advance = stage.valid && (!stage.item.last_char || !valid_ff || !rsp_stall);
   assign finish  = advance && stage.item.last_char;

   always_comb begin
      residue_in = residue_ff;
      bad_in     = bad_ff;
      if (advance) begin
         residue_in = finish ? '0 : res_now;
         bad_in     = finish ? 1'b0 : bad_now;
      end
      valid_in = valid_ff && rsp_stall;
      if (finish) begin
         valid_in = 1'b1;
      end
      result_in = result_ff;
      if (finish) begin
         result_in.invalid_input = bad_now;
         result_in.verified      = !bad_now && stage.item.operation &&
                                   (res_now == RESIDUE_ONE);
         result_in.check_tens    = (!bad_now && !stage.item.operation) ? digits[7:4]
                                                                       : 4'd0;
         result_in.check_ones    = (!bad_now && !stage.item.operation) ? digits[3:0]
                                                                       : 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         residue_ff <= '0;
         bad_ff     <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         residue_ff <= residue_in;
         bad_ff     <= bad_in;
         valid_ff   <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid = valid_ff;
   assign result    = result_ff;

endmodule

// ===== design/mod97_check_digit_stream.sv =====
// Top level of the mod 97 check digit stream: input register and fold stage.
// Depends on mcd_pkg, mcd_in_reg and mcd_fold.
//
//   Channel | Ports                                          | Direction
//   req     | req_valid req_stall req_char_code              | in
//           | req_last_char req_operation                    |
//   rsp     | rsp_valid rsp_stall rsp_check_tens             | out
//           | rsp_check_ones rsp_verified rsp_invalid_input  |
//
// One character is accepted every cycle while req_stall is low; the last one of
// a string passes the input register, and its result then goes to the result register.
// The residue table lookup, the add and the single mod 97 correction sit in the
// combinational logic between the input register and the result register.
// Reset is synchronous and clears the residue, the invalid flag and all valids.
// A stall on the result channel only holds back a last character.
module mod97_check_digit_stream (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   input  logic       req_operation,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_check_tens,
   output logic [3:0] rsp_check_ones,
   output logic       rsp_verified,
   output logic       rsp_invalid_input
);
   import mcd_pkg::*;

   item_type   req_item;
   stage_type  stage;
   logic       advance;
   result_type result;

   assign req_item.char_code = req_char_code;
   assign req_item.last_char = req_last_char;
   assign req_item.operation = req_operation;

   mcd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .advance   (advance),
      .stage     (stage)
   );

   mcd_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .result    (result)
   );

   assign rsp_check_tens    = result.check_tens;
   assign rsp_check_ones    = result.check_ones;
   assign rsp_verified      = result.verified;
   assign rsp_invalid_input = result.invalid_input;

endmodule

// ===== design/mcd_checker.sv =====
// Port checker of the mod 97 check digit stream and its bind to the top level.
// Depends on mod97_check_digit_stream_assert.svh.
`include "mod97_check_digit_stream_assert.svh"

module mcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_check_tens,
   input logic [3:0] rsp_check_ones,
   input logic       rsp_verified,
   input logic       rsp_invalid_input
);

   logic       digits_decimal;
   logic       digits_zero;
   logic       no_payload;
   logic [9:0] rsp_fields;

   assign digits_decimal = (rsp_check_tens <= 4'd9) && (rsp_check_ones <= 4'd9);
   assign digits_zero    = (rsp_check_tens == 4'd0) && (rsp_check_ones == 4'd0);
   assign no_payload     = digits_zero && !rsp_verified;
   assign rsp_fields     = {rsp_check_tens, rsp_check_ones, rsp_verified, rsp_invalid_input};

   `MCD_ASSERT_IMPLY(a_digits_decimal, clock, reset, rsp_valid, digits_decimal)
   `MCD_ASSERT_IMPLY(a_invalid_zeroes, clock, reset, rsp_valid && rsp_invalid_input, no_payload)
   `MCD_ASSERT_IMPLY(a_verified_no_check, clock, reset, rsp_valid && rsp_verified, digits_zero)
   `MCD_ASSERT_IMPLY(a_stall_from_output, clock, reset, req_stall, rsp_valid && rsp_stall)
   `MCD_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fields))

endmodule

bind mod97_check_digit_stream mcd_checker u_checker (.*);

// ===== tb/mod97_check_digit_stream_tb.sv =====
// Self-checking testbench of mod97_check_digit_stream: directed and random strings,
// with the mod 97 check values predicted and compared beat by beat.
// Depends on mcd_pkg and the RTL of the block.
module mod97_check_digit_stream_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mcd_pkg::*;

   localparam int unsigned RandomItems = 1300;
   localparam int unsigned IdleLimit   = 5000;
   localparam int unsigned ReportLimit = 10;

   class check_digit_tracker;
      result_type  pending_checks[$];
      logic [6:0]  residue;
      logic        bad_seen;
      int unsigned mismatches;

      function new();
         residue    = '0;
         bad_seen   = 1'b0;
         mismatches = 0;
      endfunction

      static function char_kind_type kind_of(logic [7:0] c);
         if (c == CHAR_HYPHEN) begin
            return KIND_SKIP;
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            return KIND_DIGIT;
         end else if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                      (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)) begin
            return KIND_LETTER;
         end
         return KIND_BAD;
      endfunction

      static function logic [6:0] fold(logic [6:0] res, logic [7:0] c);
         int unsigned r;
         r = res;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            r = (r * 10 + (c - CHAR_ZERO)) % 97;
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = (r * 100 + (c - CHAR_UPPER_A) + 10) % 97;
         end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            r = (r * 100 + (c - CHAR_LOWER_A) + 10) % 97;
         end
         return 7'(r);
      endfunction

      static function int unsigned check_value(logic [6:0] res);
         return 98 - (int'(res) * 100) % 97;
      endfunction

      function int unsigned pending();
         return pending_checks.size();
      endfunction

      function void fold_beat(logic [7:0] c, logic last, logic op);
         char_kind_type kind;
         result_type    r;
         int unsigned   chk;
         kind = kind_of(c);
         if (kind == KIND_BAD) begin
            bad_seen = 1'b1;
         end else if (kind != KIND_SKIP && !bad_seen) begin
            residue = fold(residue, c);
         end
         if (last) begin
            r = '0;
            r.invalid_input = bad_seen;
            if (!bad_seen) begin
               if (op) begin
                  r.verified = (residue == RESIDUE_ONE);
               end else begin
                  chk          = check_value(residue);
                  r.check_tens = 4'(chk / 10);
                  r.check_ones = 4'(chk % 10);
               end
            end
            pending_checks.push_back(r);
            residue  = '0;
            bad_seen = 1'b0;
         end
      endfunction

      function void compare_beat(result_type got);
         result_type want;
         if (pending_checks.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
               $display("Unexpected result beat: tens %0d ones %0d verified %0d invalid %0d",
                        got.check_tens, got.check_ones, got.verified, got.invalid_input);
            end
            return;
         end
         want = pending_checks.pop_front();
         if (got.check_tens !== want.check_tens || got.check_ones !== want.check_ones ||
             got.verified !== want.verified || got.invalid_input !== want.invalid_input) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
               $display("Result mismatch: expected tens %0d ones %0d verified %0d invalid %0d",
                        want.check_tens, want.check_ones, want.verified, want.invalid_input);
               $display("                 actual   tens %0d ones %0d verified %0d invalid %0d",
                        got.check_tens, got.check_ones, got.verified, got.invalid_input);
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code = '0;
   logic       req_last_char = 1'b0;
   logic       req_operation = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_check_tens;
   logic [3:0] rsp_check_ones;
   logic       rsp_verified;
   logic       rsp_invalid_input;

   check_digit_tracker tracker;
   item_type           stimulus[$];
   int unsigned        n_items = 0;
   int unsigned        next_item = 0;
   int unsigned        beats_sent = 0;
   int unsigned        idle_cycles = 0;
   int unsigned        phase;
   int unsigned        send_idle_pct;
   int unsigned        recv_stall_pct;

   mod97_check_digit_stream dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_last_char    (req_last_char),
      .req_operation    (req_operation),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_check_tens   (rsp_check_tens),
      .rsp_check_ones   (rsp_check_ones),
      .rsp_verified     (rsp_verified),
      .rsp_invalid_input(rsp_invalid_input)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign phase = (beats_sent < n_items / 3) ? 0 : (beats_sent < 2 * n_items / 3) ? 1 : 2;
   assign send_idle_pct  = (phase == 0) ? 25 : (phase == 1) ? 61 : 0;
   assign recv_stall_pct = (phase == 0) ? 61 : (phase == 1) ? 25 : 0;

   task automatic push_item(input logic [7:0] c, input logic last, input logic op);
      item_type it;
      it.char_code = c;
      it.last_char = last;
      it.operation = op;
      stimulus.push_back(it);
   endtask

   // The operation bit of the leading characters is the inverse, so that it is seen to be ignored.
   task automatic add_text(input string s, input logic op);
      for (int i = 0; i < s.len(); i++) begin
         push_item(8'(s[i]), i == s.len() - 1, (i == s.len() - 1) ? op : !op);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            beats_sent <= beats_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (next_item < stimulus.size() && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid     <= 1'b1;
               req_char_code <= stimulus[next_item].char_code;
               req_last_char <= stimulus[next_item].last_char;
               req_operation <= stimulus[next_item].operation;
               next_item++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            tracker.compare_beat({rsp_check_tens, rsp_check_ones, rsp_verified,
                                  rsp_invalid_input});
         end
         if (req_valid && !req_stall) begin
            tracker.fold_beat(req_char_code, req_last_char, req_operation);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IdleLimit) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      logic [7:0]  text[$];
      logic [7:0]  c;
      logic [6:0]  res;
      logic        op;
      int unsigned pick;
      int unsigned len;
      int unsigned chk;
      int unsigned directed;

      tracker = new();

      add_text("-", 1'b0);
      add_text("1", 1'b1);
      add_text("0", 1'b1);
      add_text("9", 1'b0);
      add_text("Az", 1'b0);
      add_text("aZ", 1'b1);
      add_text("7-", 1'b0);
      push_item(8'hFF, 1'b1, 1'b0);
      push_item(8'h00, 1'b1, 1'b1);
      push_item(8'h80, 1'b1, 1'b0);
      add_text("/:", 1'b0);
      add_text("@[", 1'b1);
      push_item(8'h60, 1'b0, 1'b1);
      push_item(8'h7B, 1'b1, 1'b0);
      add_text(",5", 1'b1);
      add_text("Q", 1'b1);
      directed = stimulus.size();

      while (stimulus.size() < directed + RandomItems) begin
         text.delete();
         pick = $urandom_range(0, 99);
         op   = 1'($urandom_range(0, 1));
         if (pick < 20) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               text.push_back(8'($urandom_range(0, 255)));
            end
         end else begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            res = '0;
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: c = 8'(CHAR_ZERO + $urandom_range(0, 9));
                  5, 6:          c = 8'(CHAR_UPPER_A + $urandom_range(0, 25));
                  7, 8:          c = 8'(CHAR_LOWER_A + $urandom_range(0, 25));
                  default:       c = CHAR_HYPHEN;
               endcase
               text.push_back(c);
               res = check_digit_tracker::fold(res, c);
            end
            if (op && $urandom_range(0, 1) == 1) begin
               chk = check_digit_tracker::check_value(res);
               text.push_back(8'(CHAR_ZERO + chk / 10));
               text.push_back(8'(CHAR_ZERO + chk % 10));
            end
            if (pick < 30) begin
               text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            end
         end
         for (int i = 0; i < text.size(); i++) begin
            push_item(text[i], i == text.size() - 1,
                      (i == text.size() - 1) ? op : 1'($urandom_range(0, 1)));
         end
      end
      n_items = stimulus.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (beats_sent < n_items || tracker.pending() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// ===== mod97_check_digit_stream.f =====
+incdir+design
design/mcd_pkg.sv
design/mcd_in_reg.sv
design/mcd_fold.sv
design/mod97_check_digit_stream.sv
design/mcd_checker.sv
tb/mod97_check_digit_stream_tb.sv
